// ----- rtl/core/sfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, codes and the CRC16 byte update of the framed serial receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // Parser phase codes
    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_CMD  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_CRCH = 3'd5;
    localparam logic [2:0] PH_CRCL = 3'd6;

    // Frame status codes
    localparam logic [1:0] ST_CRC_GOOD  = 2'd0;
    localparam logic [1:0] ST_CRC_BAD   = 2'd1;
    localparam logic [1:0] ST_SHORT_LEN = 2'd2;
    localparam logic [1:0] ST_TIMEOUT   = 2'd3;

    // Input kind carried on tuser
    localparam logic MODE_BYTE    = 1'b0;
    localparam logic MODE_TIMEOUT = 1'b1;

    localparam logic [7:0]  SYNC_BYTE0 = 8'h55;
    localparam logic [7:0]  SYNC_BYTE1 = 8'hAA;
    localparam logic [7:0]  MIN_LEN    = 8'd3;
    localparam logic [15:0] CRC_POLY   = 16'h8005;
    localparam logic [15:0] CRC_SEED_RESET = 16'hFFFF;

    // One result beat
    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_out;
        logic       frame_end;
        logic [1:0] frame_status;
        logic [7:0] command_out;
    } sfr_result_t;

    // CRC16 update over one byte, MSB first, no reflection
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/serial_frame_receiver_crc16.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc16
// Framed serial receiver: header sync, length, command, data pass-through and
// CRC16 (poly 0x8005) check, one result beat for every input beat.
// ----------------------------------------------------------------------------
// Path: an accepted input beat passes through the input register, then the
//   result register, which it enters when the result side is free.
// Throughput: one beat per cycle while the result side accepts; the one-byte
//   CRC update sits between the input register and the result register.
// Reset: synchronous, active low; parser returns to header search, CRC seed
//   register returns to 0xFFFF, both pipeline stages empty.
// ----------------------------------------------------------------------------
module serial_frame_receiver_crc16 (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,     // crc_seed
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] rx_byte
    input  logic        s_tuser,       // [0] mode
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,       // [7:0] data_out, [9:8] frame_status,
                                       // [17:10] command_out, [23:18] zero
    output logic        m_tlast,       // frame_end
    output logic        m_tuser        // [0] data_valid
);
    import sfr_pkg::*;

    logic [15:0]  crc_seed_reg;
    logic         in_valid_reg;
    logic         in_mode_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    sfr_result_t  out_reg;
    sfr_result_t  result;
    logic         advance;

    // Move a beat from the input register to the result register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Hold the CRC seed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_seed_reg <= CRC_SEED_RESET;
        end else if (cfg_we) begin
            crc_seed_reg <= cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    sfr_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .mode     (in_mode_reg),
        .rx_byte  (in_byte_reg),
        .crc_seed (crc_seed_reg),
        .result   (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.command_out, out_reg.frame_status, out_reg.data_out};
    assign m_tlast  = out_reg.frame_end;
    assign m_tuser  = out_reg.data_valid;

endmodule

// ----- rtl/core/sfr_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_parser
// Frame parser state and CRC register; works out the result of one byte beat
// and advances the state when the beat is taken.
// ----------------------------------------------------------------------------
module sfr_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic                 mode,
    input  logic [7:0]           rx_byte,
    input  logic [15:0]          crc_seed,
    output sfr_pkg::sfr_result_t result
);
    import sfr_pkg::*;

    logic [2:0]  phase_reg,       phase_next;
    logic [7:0]  byte_pos_reg,    byte_pos_next;
    logic [7:0]  frame_len_reg,   frame_len_next;
    logic [15:0] crc_reg,         crc_next;
    logic [7:0]  command_reg,     command_next;
    logic        sync_match_reg,  sync_match_next;
    logic        crc_hi_ok_reg,   crc_hi_ok_next;

    logic [15:0] crc_upd;
    logic [15:0] crc_first;
    logic [8:0]  pos_plus2;

    assign crc_upd   = crc16_byte(crc_reg, rx_byte);
    assign crc_first = crc16_byte(crc_seed, rx_byte);
    // Advanced body position plus the two CRC bytes
    assign pos_plus2 = {1'b0, byte_pos_reg + 8'd1} + 9'd2;

    // Work out next state and result for the current beat
    always_comb begin
        phase_next      = phase_reg;
        byte_pos_next   = byte_pos_reg;
        frame_len_next  = frame_len_reg;
        crc_next        = crc_reg;
        command_next    = command_reg;
        sync_match_next = sync_match_reg;
        crc_hi_ok_next  = crc_hi_ok_reg;
        result          = '0;

        if (mode == MODE_TIMEOUT) begin
            // Abort a frame body; drop a partial header silently
            if (phase_reg inside {[PH_CMD:PH_CRCL]}) begin
                result.frame_end    = 1'b1;
                result.frame_status = ST_TIMEOUT;
                result.command_out  = command_reg;
            end
            phase_next      = PH_HDR0;
            byte_pos_next   = '0;
            sync_match_next = 1'b0;
            crc_hi_ok_next  = 1'b0;
        end else begin
            case (phase_reg)
                PH_HDR1: begin
                    crc_next        = crc_upd;
                    sync_match_next = sync_match_reg && (rx_byte == SYNC_BYTE1);
                    phase_next      = PH_LEN;
                end
                PH_LEN: begin
                    crc_next = crc_upd;
                    if (!sync_match_reg || (rx_byte < MIN_LEN)) begin
                        if (sync_match_reg) begin
                            result.frame_end    = 1'b1;
                            result.frame_status = ST_SHORT_LEN;
                        end
                        phase_next      = PH_HDR0;
                        byte_pos_next   = '0;
                        sync_match_next = 1'b0;
                        crc_hi_ok_next  = 1'b0;
                    end else begin
                        frame_len_next = rx_byte;
                        byte_pos_next  = '0;
                        command_next   = '0;
                        phase_next     = PH_CMD;
                    end
                end
                PH_CMD: begin
                    crc_next      = crc_upd;
                    command_next  = rx_byte;
                    byte_pos_next = 8'd1;
                    phase_next    = (frame_len_reg == MIN_LEN) ? PH_CRCH : PH_DATA;
                end
                PH_DATA: begin
                    crc_next          = crc_upd;
                    result.data_valid = 1'b1;
                    result.data_out   = rx_byte;
                    byte_pos_next     = byte_pos_reg + 8'd1;
                    if (pos_plus2 >= {1'b0, frame_len_reg}) begin
                        phase_next = PH_CRCH;
                    end
                end
                PH_CRCH: begin
                    crc_hi_ok_next = (rx_byte == crc_reg[15:8]);
                    byte_pos_next  = byte_pos_reg + 8'd1;
                    phase_next     = PH_CRCL;
                end
                PH_CRCL: begin
                    result.frame_end    = 1'b1;
                    result.frame_status = (crc_hi_ok_reg && (rx_byte == crc_reg[7:0]))
                                          ? ST_CRC_GOOD : ST_CRC_BAD;
                    result.command_out  = command_reg;
                    phase_next      = PH_HDR0;
                    byte_pos_next   = '0;
                    sync_match_next = 1'b0;
                    crc_hi_ok_next  = 1'b0;
                end
                default: begin
                    // First header byte: restart the CRC from the seed
                    crc_next        = crc_first;
                    sync_match_next = (rx_byte == SYNC_BYTE0);
                    crc_hi_ok_next  = 1'b0;
                    phase_next      = PH_HDR1;
                end
            endcase
        end
    end

    // Advance parser state on each taken beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HDR0;
            byte_pos_reg   <= '0;
            frame_len_reg  <= '0;
            crc_reg        <= CRC_SEED_RESET;
            command_reg    <= '0;
            sync_match_reg <= 1'b0;
            crc_hi_ok_reg  <= 1'b0;
        end else if (step) begin
            phase_reg      <= phase_next;
            byte_pos_reg   <= byte_pos_next;
            frame_len_reg  <= frame_len_next;
            crc_reg        <= crc_next;
            command_reg    <= command_next;
            sync_match_reg <= sync_match_next;
            crc_hi_ok_reg  <= crc_hi_ok_next;
        end
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the framed serial receiver with CRC16 check. Bytes
// and timeout events are streamed in with bursty gaps while the result side
// stalls on its own pattern. A local parser and CRC model predicts every
// result beat, and the checker compares each one with the oldest prediction.
// The run covers fixed frame and error cases first, then random traffic under
// several CRC seeds.
// ----------------------------------------------------------------------------
module tb_top;
    import sfr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BEATS = 150;

    // Clock, reset and DUT ports
    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // [7:0] rx_byte
    logic        s_tuser;      // [0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;      // [7:0] data_out, [9:8] frame_status, [17:10] command_out
    logic        m_tlast;      // frame_end
    logic        m_tuser;      // [0] data_valid

    // Parser model state
    logic [2:0]  rx_phase;
    logic [7:0]  body_pos;
    logic [7:0]  frame_len;
    logic [15:0] crc_acc;
    logic [7:0]  cmd_latch;
    logic        sync_ok;
    logic        crc_hi_ok;
    logic [15:0] seed_value;

    // Predicted result beats, oldest first
    sfr_result_t pending_results[$];

    // Run statistics
    int n_err       = 0;
    int n_beats_in  = 0;
    int n_checked   = 0;
    int n_data_out  = 0;
    int n_seeds     = 0;
    int cycle_count = 0;
    int status_seen[4] = '{0, 0, 0, 0};

    // Sender burst shaping and receiver stall pattern
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;

    serial_frame_receiver_crc16 u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Abort on a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------

    // CRC16 over one byte, poly 0x8005, MSB first
    function automatic logic [15:0] crc16_step(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = {c[14:0], 1'b0} ^ (c[15] ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic void restart_search();
        rx_phase  = PH_HDR0;
        body_pos  = 8'd0;
        sync_ok   = 1'b0;
        crc_hi_ok = 1'b0;
    endfunction

    function automatic void reset_parser_model();
        seed_value = CRC_SEED_RESET;
        restart_search();
        frame_len  = 8'd0;
        crc_acc    = CRC_SEED_RESET;
        cmd_latch  = 8'd0;
    endfunction

    // Advance the parser by one input beat and return the result beat it gives
    function automatic sfr_result_t parse_rx_beat(input logic mode, input logic [7:0] b);
        sfr_result_t r;
        r = '0;
        if (mode == MODE_TIMEOUT) begin
            if (rx_phase >= PH_CMD && rx_phase <= PH_CRCL) begin
                r.frame_end    = 1'b1;
                r.frame_status = ST_TIMEOUT;
                r.command_out  = cmd_latch;
            end
            restart_search();
        end else begin
            case (rx_phase)
                PH_HDR1: begin
                    crc_acc  = crc16_step(crc_acc, b);
                    sync_ok  = sync_ok && (b == SYNC_BYTE1);
                    rx_phase = PH_LEN;
                end
                PH_LEN: begin
                    crc_acc = crc16_step(crc_acc, b);
                    if (!sync_ok) begin
                        restart_search();
                    end else if (b < MIN_LEN) begin
                        r.frame_end    = 1'b1;
                        r.frame_status = ST_SHORT_LEN;
                        restart_search();
                    end else begin
                        frame_len = b;
                        body_pos  = 8'd0;
                        cmd_latch = 8'd0;
                        rx_phase  = PH_CMD;
                    end
                end
                PH_CMD: begin
                    crc_acc   = crc16_step(crc_acc, b);
                    cmd_latch = b;
                    body_pos  = 8'd1;
                    rx_phase  = (frame_len == MIN_LEN) ? PH_CRCH : PH_DATA;
                end
                PH_DATA: begin
                    crc_acc      = crc16_step(crc_acc, b);
                    r.data_valid = 1'b1;
                    r.data_out   = b;
                    body_pos     = body_pos + 8'd1;
                    if (int'(body_pos) + 2 >= int'(frame_len)) begin
                        rx_phase = PH_CRCH;
                    end
                end
                PH_CRCH: begin
                    crc_hi_ok = (b == crc_acc[15:8]);
                    body_pos  = body_pos + 8'd1;
                    rx_phase  = PH_CRCL;
                end
                PH_CRCL: begin
                    r.frame_end    = 1'b1;
                    r.frame_status = (crc_hi_ok && b == crc_acc[7:0]) ? ST_CRC_GOOD
                                                                       : ST_CRC_BAD;
                    r.command_out  = cmd_latch;
                    restart_search();
                end
                default: begin
                    crc_acc   = crc16_step(seed_value, b);
                    sync_ok   = (b == SYNC_BYTE0);
                    crc_hi_ok = 1'b0;
                    rx_phase  = PH_HDR1;
                end
            endcase
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Drive one beat in bursts with random gaps, then predict its result
    task automatic send_beat(input logic mode, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 5) == 0) begin
                burst_left = 40;
                gap        = 0;
            end else begin
                burst_left = $urandom_range(1, 16);
                gap        = $urandom_range(0, 6);
            end
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= mode;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(parse_rx_beat(mode, b));
        n_beats_in++;
    endtask

    // Hold the sender off until every predicted beat has been checked
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [15:0] value);
        drain_results();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        seed_value = value;
        n_seeds++;
    endtask

    // Send one frame with random data; optionally spoil the CRC or replace
    // the beat at position abort_at (counted from the first sync byte) by a
    // timeout, which ends the frame there
    task automatic send_frame(input logic [7:0] cmd, input int n_data,
                              input bit bad_crc, input int abort_at);
        logic [7:0]  frame_q[$];
        logic [15:0] c;
        logic [7:0]  flip;
        frame_q = {SYNC_BYTE0, SYNC_BYTE1, 8'(n_data + 3), cmd};
        for (int i = 0; i < n_data; i++) begin
            frame_q.push_back(8'($urandom_range(0, 255)));
        end
        c = seed_value;
        foreach (frame_q[i]) c = crc16_step(c, frame_q[i]);
        if (bad_crc) begin
            flip = 8'($urandom_range(1, 255));
            if ($urandom_range(0, 1) == 0) begin
                c[15:8] = c[15:8] ^ flip;
            end else begin
                c[7:0] = c[7:0] ^ flip;
            end
        end
        frame_q.push_back(c[15:8]);
        frame_q.push_back(c[7:0]);
        foreach (frame_q[k]) begin
            if (k == abort_at) begin
                send_beat(MODE_TIMEOUT, 8'($urandom_range(0, 255)));
                return;
            end
            send_beat(MODE_BYTE, frame_q[k]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Fixed cases under the reset seed
    task automatic test_frame_cases();
        // bad sync group, also the byte extremes
        send_beat(MODE_BYTE, 8'h00);
        send_beat(MODE_BYTE, 8'hFF);
        send_beat(MODE_BYTE, 8'h12);
        // length just below the minimum
        send_beat(MODE_BYTE, SYNC_BYTE0);
        send_beat(MODE_BYTE, SYNC_BYTE1);
        send_beat(MODE_BYTE, 8'h02);
        // timeout inside the sync group
        send_beat(MODE_BYTE, SYNC_BYTE0);
        send_beat(MODE_TIMEOUT, 8'hFF);
        // command only, good CRC
        send_frame(8'hA5, 0, 1'b0, -1);
        // one data byte, spoilt CRC
        send_frame(8'h00, 1, 1'b1, -1);
        // timeout right after the command byte
        send_frame(8'hC3, 2, 1'b0, 4);
        drain_results();
    endtask

    // Seed extremes
    task automatic test_seed_extremes();
        write_seed(16'h0000);
        send_frame(8'($urandom_range(0, 255)), 2, 1'b0, -1);
        write_seed(16'hFFFF);
        send_frame(8'($urandom_range(0, 255)), 2, 1'b0, -1);
        drain_results();
    endtask

    // Longest frame the length byte allows
    task automatic test_max_length_frame();
        write_seed(16'($urandom_range(0, 65535)));
        send_frame(8'($urandom_range(0, 255)), 252, 1'b0, -1);
        drain_results();
    endtask

    // Mostly well-formed frames with random content, plus noise and errors
    task automatic test_random_traffic();
        int stop_at;
        int seed_mark;
        int pick;
        int n_data;
        int len_total;
        int abort_at;
        int n_noise;
        stop_at   = n_beats_in + RANDOM_BEATS;
        seed_mark = n_beats_in;
        while (n_beats_in < stop_at) begin
            if (n_beats_in - seed_mark >= 60) begin
                write_seed(16'($urandom_range(0, 65535)));
                seed_mark = n_beats_in;
            end else if ($urandom_range(0, 39) == 0) begin
                drain_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                n_data    = $urandom_range(0, 10);
                len_total = n_data + 6;
                abort_at  = ($urandom_range(0, 6) == 0) ? $urandom_range(0, len_total - 1)
                                                        : -1;
                send_frame(8'($urandom_range(0, 255)), n_data,
                           ($urandom_range(0, 4) == 0), abort_at);
            end else if (pick < 80) begin
                // sync group with a short length or a broken second byte
                send_beat(MODE_BYTE, SYNC_BYTE0);
                send_beat(MODE_BYTE, ($urandom_range(0, 3) == 0) ?
                                     8'($urandom_range(0, 255)) : SYNC_BYTE1);
                send_beat(MODE_BYTE, 8'($urandom_range(0, 2)));
            end else if (pick < 92) begin
                // noise, usually cleared by a timeout so the next frame lines up
                n_noise = $urandom_range(1, 6);
                repeat (n_noise) begin
                    case ($urandom_range(0, 7))
                        0:       send_beat(MODE_TIMEOUT, 8'($urandom_range(0, 255)));
                        1:       send_beat(MODE_BYTE, SYNC_BYTE0);
                        2:       send_beat(MODE_BYTE, SYNC_BYTE1);
                        default: send_beat(MODE_BYTE, 8'($urandom_range(0, 255)));
                    endcase
                end
                if ($urandom_range(0, 3) != 0) begin
                    send_beat(MODE_TIMEOUT, 8'($urandom_range(0, 255)));
                end
            end else begin
                send_beat(MODE_TIMEOUT, 8'($urandom_range(0, 255)));
            end
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall pattern and checker
    // ------------------------------------------------------------------------

    // Pick a new stall style each time the random hold counter runs out
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 80);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ~m_tready;
        endcase
    end

    task automatic note_failure(input string msg);
        n_err++;
        if (n_err <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Compare each accepted result beat with the oldest prediction
    always @(posedge aclk) begin
        sfr_result_t got;
        sfr_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.data_valid   = m_tuser;
            got.data_out     = m_tdata[7:0];
            got.frame_end    = m_tlast;
            got.frame_status = m_tdata[9:8];
            got.command_out  = m_tdata[17:10];
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected beat dv=%0b data=%02h end=%0b st=%0d cmd=%02h",
                             got.data_valid, got.data_out, got.frame_end,
                             got.frame_status, got.command_out));
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (got.frame_end) status_seen[got.frame_status]++;
                if (got.data_valid) n_data_out++;
                if (got.data_valid !== want.data_valid || got.data_out !== want.data_out ||
                    got.frame_end !== want.frame_end ||
                    got.frame_status !== want.frame_status ||
                    got.command_out !== want.command_out) begin
                    note_failure({
                        $sformatf("beat %0d exp dv=%0b data=%02h end=%0b st=%0d cmd=%02h",
                                  n_checked, want.data_valid, want.data_out, want.frame_end,
                                  want.frame_status, want.command_out),
                        $sformatf(", got dv=%0b data=%02h end=%0b st=%0d cmd=%02h",
                                  got.data_valid, got.data_out, got.frame_end,
                                  got.frame_status, got.command_out)});
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 16'h0000;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tuser   = MODE_BYTE;
        m_tready  = 1'b0;
        reset_parser_model();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_frame_cases();
        test_seed_extremes();
        test_max_length_frame();
        test_random_traffic();

        drain_results();
        repeat (10) @(posedge aclk);
        $display("Run covered %0d input beats and %0d checked results over %0d seed writes.",
                 n_beats_in, n_checked, n_seeds);
        $display("Frame ends: %0d good, %0d bad CRC, %0d short, %0d timeout; %0d data bytes.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3], n_data_out);
        if (n_err == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", n_err);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
